/* hdl/bse_pkg.sv */
package bse_pkg;

   localparam int MAX_KEYS    = 64;
   localparam int MAX_BUCKETS = 8;
   localparam int KEY_W       = 31;
   localparam int CFG_W       = 4;
   localparam int ADDR_W      = $clog2(MAX_KEYS);
   localparam int CNT_W       = $clog2(MAX_KEYS + 1);
   localparam int BKT_W       = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
   localparam int TUP_W       = BKT_W + KEY_W + ADDR_W;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);
   localparam logic [KEY_W-1:0] FULL_RANGE = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [KEY_W-1:0] key_value;
      logic             last_key;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_value;
      logic             final_result;
      logic             overflow_flag;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [BKT_W-1:0] bkt;
      logic             last;
   } item_type;

   typedef struct packed {
      logic [BKT_W-1:0] bkt;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // bucket = number of thresholds j*span (0 < j < n) that the key reaches
   function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] key,
                                                  input logic [CFG_W-1:0] cfg);
      logic [CFG_W-1:0] n;
      logic [KEY_W-1:0] span;
      logic [KEY_W+2:0] thr;
      logic [BKT_W-1:0] idx;
      n = cfg;
      if (n == '0) n = CFG_W'(1);
      if (n > CFG_W'(MAX_BUCKETS)) n = CFG_W'(MAX_BUCKETS);
      case (n)
         CFG_W'(1): span = FULL_RANGE / 1;
         CFG_W'(2): span = FULL_RANGE / 2;
         CFG_W'(3): span = FULL_RANGE / 3;
         CFG_W'(4): span = FULL_RANGE / 4;
         CFG_W'(5): span = FULL_RANGE / 5;
         CFG_W'(6): span = FULL_RANGE / 6;
         CFG_W'(7): span = FULL_RANGE / 7;
         CFG_W'(8): span = FULL_RANGE / 8;
         default:   span = FULL_RANGE / 8;
      endcase
      idx = '0;
      for (int j = 1; j < MAX_BUCKETS; j++) begin
         thr = (KEY_W+3)'(j) * {3'b000, span};
         if ((CFG_W'(j) < n) && ({3'b000, key} >= thr)) idx = BKT_W'(j);
      end
      return idx;
   endfunction

endpackage

/* hdl/bucket_sort_engine_top.sv */
// Bucket sort engine.
// req_ channel: one key per beat (valid/stall); last_key closes the batch.
// Keys are binned into bucket_count value ranges on arrival and queued in a
// four-beat queue; the back end stores them (up to 64 per batch, more are
// dropped and flag overflow on every result of that batch).
// csr_ channel: writes bucket_count (reset 8); csr_ready is always high.
// Keys enter at one per cycle while the back end is loading.
// After the last key, the back end scans the key store once per result
// through its single registered read port, picking the next larger
// (bucket, key, index) tuple, so equal keys each give a result. Input is
// stalled by the queue filling while results drain.
// rsp_ channel: results in ascending order within bucket order, final_result
// on the last beat. A stalled result beat is held; the scan resumes when it
// is taken.
// Synchronous reset empties the queue and the batch, restores bucket_count.
module bucket_sort_engine_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bse_pkg::req_type          req_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [bse_pkg::CFG_W-1:0] csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bse_pkg::rsp_type          rsp_data
);
   import bse_pkg::*;

   logic     q_valid, q_pop;
   item_type q_item;

   bse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   bse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/bse_ram.sv */
module bse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bse_front.sv */
module bse_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bse_pkg::req_type            req_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bse_pkg::CFG_W-1:0]   csr_data,
   output logic                        q_valid,
   output bse_pkg::item_type           q_item,
   input  logic                        q_pop
);
   import bse_pkg::*;

   logic [CFG_W-1:0]   cfg_ff, cfg_in;
   item_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic               push, pop;
   item_type           new_item;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff == FIFO_CW'(FIFO_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != '0);
   assign q_valid   = (count_ff != '0);
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_comb begin
      new_item.key  = req_data.key_value;
      new_item.bkt  = bucket_of(req_data.key_value, cfg_ff);
      new_item.last = req_data.last_key;
      cfg_in    = (csr_valid && csr_ready) ? csr_data : cfg_ff;
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= CFG_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= new_item;
   end

endmodule

/* hdl/bse_back.sv */
module bse_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  bse_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bse_pkg::rsp_type  rsp_data
);
   import bse_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, ptr_ff, ptr_in, emitted_ff, emitted_in;
   logic              ovf_ff, ovf_in, rv_ff, rv_in;
   logic [ADDR_W-1:0] ridx_ff, ridx_in;
   logic [TUP_W-1:0]  prev_ff, prev_in, best_ff, best_in, cand;
   logic              have_prev_ff, have_prev_in, best_v_ff, best_v_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   entry_type         wr_entry, rd_entry;
   logic              scan_done;

   bse_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_KEYS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign scan_done = (ptr_ff == cnt_ff) && !rv_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign q_pop     = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: if (q_valid && q_item.last) state_in = ST_SCAN;
         ST_SCAN: if (scan_done) state_in = ST_EMIT;
         ST_EMIT: begin
            if (!rsp_stall) state_in = rsp_data_ff.final_result ? ST_LOAD : ST_SCAN;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      ptr_in       = ptr_ff;
      rv_in        = 1'b0;
      ridx_in      = ridx_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      best_in      = best_ff;
      best_v_in    = best_v_ff;
      emitted_in   = emitted_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_entry.bkt = q_item.bkt;
      wr_entry.key = q_item.key;
      rd_addr      = ptr_ff[ADDR_W-1:0];
      cand         = {rd_entry.bkt, rd_entry.key, ridx_ff};
      case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               if (cnt_ff < CNT_W'(MAX_KEYS)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (q_item.last) begin
                  ptr_in       = '0;
                  have_prev_in = 1'b0;
                  best_v_in    = 1'b0;
                  emitted_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            if (ptr_ff < cnt_ff) begin
               ptr_in  = ptr_ff + CNT_W'(1);
               rv_in   = 1'b1;
               ridx_in = ptr_ff[ADDR_W-1:0];
            end
            if (rv_ff && (!have_prev_ff || cand > prev_ff)
                && (!best_v_ff || cand < best_ff)) begin
               best_in   = cand;
               best_v_in = 1'b1;
            end
            if (scan_done) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.sorted_value  = best_ff[ADDR_W +: KEY_W];
               rsp_data_in.final_result  = ((emitted_ff + CNT_W'(1)) == cnt_ff);
               rsp_data_in.overflow_flag = ovf_ff;
               prev_in                   = best_ff;
               have_prev_in              = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               emitted_in   = emitted_ff + CNT_W'(1);
               if (rsp_data_ff.final_result) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  ptr_in    = '0;
                  best_v_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         ptr_ff       <= '0;
         rv_ff        <= 1'b0;
         have_prev_ff <= 1'b0;
         best_v_ff    <= 1'b0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         ptr_ff       <= ptr_in;
         rv_ff        <= rv_in;
         have_prev_ff <= have_prev_in;
         best_v_ff    <= best_v_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff     <= ridx_in;
      prev_ff     <= prev_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
